>>> src/i2cbm_pkg.sv
// Shared types, codes and phase constants for the I2C bit-level master.
// No dependencies; used by i2cbm_phase and i2c_bit_level_master.
package i2cbm_pkg;

   // request kinds on the tuser field
   localparam logic [2:0] FUNC_TICK  = 3'd0;
   localparam logic [2:0] FUNC_START = 3'd1;
   localparam logic [2:0] FUNC_STOP  = 3'd2;
   localparam logic [2:0] FUNC_WRITE = 3'd3;
   localparam logic [2:0] FUNC_READ  = 3'd4;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 16;

   localparam logic [7:0] TOP_BIT = 8'b1000_0000;

   // phase numbers that end a section of a command
   localparam logic [4:0] PH_FIRST       = 5'd0;
   localparam logic [4:0] PH_SECOND      = 5'd1;
   localparam logic [4:0] PH_THIRD       = 5'd2;
   localparam logic [4:0] PH_WR_BITS_END = 5'd24;
   localparam logic [4:0] PH_WR_SCL_HIGH = 5'd25;
   localparam logic [4:0] PH_RD_BITS_END = 5'd27;
   localparam logic [4:0] PH_RD_ACK_LVL  = 5'd28;
   localparam logic [4:0] PH_RD_SCL_HIGH = 5'd29;
   localparam logic [4:0] PH_MAX         = 5'd30;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   typedef struct packed {
      logic [4:0] phase;
      cmd_type    cmd;
      logic [7:0] shift;
      logic       ack;
      logic       busy;
      logic       scl;
      logic       sda;
      logic       sda_en;
      logic       nack;
      logic [7:0] rd_byte;
   } state_type;

   typedef struct packed {
      logic       nack;
      logic [7:0] read_data;
      logic       done_res;
      logic       busy_res;
      logic       sda_drive;
      logic       sda_out;
      logic       scl;
   } rsp_type;

   // remainder by three of a 5-bit phase: reciprocal multiply, then subtract
   function automatic logic [1:0] mod3_5(input logic [4:0] v);
      logic [8:0] prod;
      logic [3:0] q;
      logic [5:0] t;
      prod = {4'b0, v} * 9'd11;
      q    = prod[8:5];
      t    = {1'b0, v} - ({2'b0, q} * 6'd3);
      return t[1:0];
   endfunction

endpackage

>>> src/i2cbm_phase.sv
// Next-state logic: starts a command and runs one bus phase per item.
// Depends on i2cbm_pkg.
module i2cbm_phase
   import i2cbm_pkg::*;
(
   input  state_type  st,
   input  logic [2:0] func,
   input  logic [7:0] wr_data,
   input  logic       ack_req,
   input  logic       sda_in,
   output state_type  nxt,
   output rsp_type    rsp
);

   state_type  s;
   logic [4:0] p;
   logic [1:0] r;
   logic [2:0] func_off;
   logic       last;
   logic       busy_o;
   logic       done_o;

   always_comb begin
      s        = st;
      last     = 1'b0;
      busy_o   = 1'b0;
      done_o   = 1'b0;
      func_off = func - FUNC_START;

      if (!s.busy && func >= FUNC_START && func <= FUNC_READ) begin
         s.busy  = 1'b1;
         s.cmd   = cmd_type'(func_off[1:0]);
         s.phase = PH_FIRST;
         s.ack   = ack_req;
         s.shift = (func == FUNC_WRITE) ? wr_data : 8'd0;
      end

      p = s.phase;
      r = mod3_5(p);

      if (s.busy) begin
         busy_o = 1'b1;
         case (s.cmd)
            CMD_START: begin
               if (p == PH_FIRST) begin
                  s.sda_en = 1'b1;
                  s.sda    = 1'b0;
               end else begin
                  s.scl = 1'b0;
                  last  = 1'b1;
               end
            end
            CMD_STOP: begin
               s.sda_en = 1'b1;
               if (p == PH_FIRST) begin
                  s.sda = 1'b0;
               end else if (p == PH_SECOND) begin
                  s.scl = 1'b1;
               end else begin
                  s.sda = 1'b1;
                  last  = 1'b1;
               end
            end
            CMD_WRITE: begin
               if (p < PH_WR_BITS_END) begin
                  // three phases per bit: data, clock high, clock low
                  if (r == 2'd0) begin
                     s.sda_en = 1'b1;
                     s.sda    = |(s.shift & TOP_BIT);
                     s.shift  = {s.shift[6:0], 1'b0};
                  end else if (r == 2'd1) begin
                     s.scl = 1'b1;
                  end else begin
                     s.scl = 1'b0;
                  end
               end else if (p == PH_WR_BITS_END) begin
                  s.sda_en = 1'b1;
                  s.sda    = 1'b1;
               end else if (p == PH_WR_SCL_HIGH) begin
                  s.scl = 1'b1;
               end else begin
                  s.sda_en = 1'b0;
                  s.nack   = sda_in;
                  last     = 1'b1;
               end
            end
            CMD_READ: begin
               if (p == PH_FIRST) begin
                  s.scl = 1'b0;
               end else if (p == PH_SECOND) begin
                  s.sda = 1'b1;
               end else if (p == PH_THIRD) begin
                  s.sda_en = 1'b0;
               end else if (p < PH_RD_BITS_END) begin
                  // (p - 3) mod 3 equals p mod 3
                  if (r == 2'd0) begin
                     s.scl = 1'b1;
                  end else if (r == 2'd1) begin
                     s.shift = {s.shift[6:0], sda_in};
                  end else begin
                     s.scl = 1'b0;
                  end
               end else if (p == PH_RD_BITS_END) begin
                  s.sda_en = 1'b1;
               end else if (p == PH_RD_ACK_LVL) begin
                  s.sda = ~s.ack;
               end else if (p == PH_RD_SCL_HIGH) begin
                  s.scl = 1'b1;
               end else begin
                  s.scl     = 1'b0;
                  s.rd_byte = s.shift;
                  last      = 1'b1;
               end
            end
            default: begin
               last = 1'b1;
            end
         endcase

         if (last) begin
            done_o  = 1'b1;
            s.busy  = 1'b0;
            s.phase = PH_FIRST;
         end else begin
            s.phase = p + 5'd1;
         end
      end

      rsp.scl       = s.scl;
      rsp.sda_out   = s.sda;
      rsp.sda_drive = s.sda_en;
      rsp.busy_res  = busy_o;
      rsp.done_res  = done_o;
      rsp.read_data = s.rd_byte;
      rsp.nack      = s.nack;

      // after the write acknowledge the master takes SDA back and drops SCL
      if (done_o && s.cmd == CMD_WRITE) begin
         s.sda_en = 1'b1;
         s.scl    = 1'b0;
      end

      nxt = s;
   end

endmodule

>>> src/i2c_bit_level_master.sv
// I2C bit-level master: one item per bus phase, input register, phase logic, result register.
// Depends on i2cbm_pkg and i2cbm_phase.
//
// Each request item is one bus phase. While idle, an item whose tuser kind is start, stop,
// write or read begins that command and its first phase runs on the same item; start takes
// 2 items, stop 3, write 27 and read 31, and kinds that arrive while busy are ignored. Every
// request gives exactly one response item with the line levels after that phase, busy and
// done flags, the last read byte and the last write's nack. The block takes one item per
// clock while the response side accepts: an item is held in the input register, goes
// through the phase logic and lands in the result register, so the rate is set only by
// the response side's tready. Reset leaves SCL and SDA high with SDA driven.
module i2c_bit_level_master
   import i2cbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] wr_data, [8] ack_req, [9] sda_in, [15:10] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] func
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
   // [12:5] read_data, [13] nack, [15:14] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam state_type STATE_RESET = '{
      phase:   PH_FIRST,
      cmd:     CMD_START,
      shift:   8'd0,
      ack:     1'b0,
      busy:    1'b0,
      scl:     1'b1,
      sda:     1'b1,
      sda_en:  1'b1,
      nack:    1'b0,
      rd_byte: 8'd0
   };

   logic                  in_valid_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic [REQ_USER_W-1:0] in_user_ff;
   logic                  out_valid_ff;
   rsp_type               out_ff;
   rsp_type               out_in;
   state_type             state_ff;
   state_type             state_in;
   logic                  advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   i2cbm_phase u_phase (
      .st       (state_ff),
      .func     (in_user_ff),
      .wr_data  (in_data_ff[7:0]),
      .ack_req  (in_data_ff[8]),
      .sda_in   (in_data_ff[9]),
      .nxt      (state_in),
      .rsp      (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_user_ff <= req_tuser;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_type)){1'b0}}, out_ff};

   // an idle master always sits at the first phase
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      !state_ff.busy |-> state_ff.phase == PH_FIRST)
      else $error("idle with nonzero phase");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase <= PH_MAX)
      else $error("phase count beyond last phase");

   a_write_release: assert property (@(posedge clock) disable iff (reset)
      advance && out_in.done_res && state_in.cmd == CMD_WRITE
      |=> state_ff.sda_en && !state_ff.scl)
      else $error("write end did not retake sda and drop scl");

   a_in_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff) && $stable(in_user_ff))
      else $error("stalled input item lost");

endmodule

>>> tb/i2cbm_line_checker.sv
// Checker for the I2C bit-level master: watches both streams, predicts each response item.
// Depends on i2cbm_pkg; instantiated beside the block by i2c_bit_level_master_tb.
module i2cbm_line_checker
   import i2cbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // [7:0] wr_data, [8] ack_req, [9] sda_in, [15:10] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] func
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
   // [12:5] read_data, [13] nack, [15:14] zero
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    mismatches,
   output int                    outstanding
);

   // predicted bus state
   logic [4:0] bus_phase;
   cmd_type    bus_cmd;
   logic [7:0] shift_reg;
   logic       ack_sel;
   logic       cmd_busy;
   logic       scl_q;
   logic       sda_q;
   logic       sda_en_q;
   logic       nack_q;
   logic [7:0] rd_byte_q;

   rsp_type expected_lines[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic rsp_type advance_bus_phase(input logic [2:0] func, input logic [7:0] wr,
                                                 input logic ack_in, input logic sda_in);
      rsp_type    r;
      logic       last;
      logic [4:0] p;
      r    = '0;
      last = 1'b0;
      if (!cmd_busy && func >= FUNC_START && func <= FUNC_READ) begin
         cmd_busy  = 1'b1;
         bus_cmd   = cmd_type'(2'(func - FUNC_START));
         bus_phase = PH_FIRST;
         ack_sel   = ack_in;
         shift_reg = (bus_cmd == CMD_WRITE) ? wr : 8'h00;
      end
      if (cmd_busy) begin
         r.busy_res = 1'b1;
         p = bus_phase;
         case (bus_cmd)
            CMD_START: begin
               if (p == PH_FIRST) begin
                  sda_en_q = 1'b1;
                  sda_q    = 1'b0;
               end else begin
                  scl_q = 1'b0;
                  last  = 1'b1;
               end
            end
            CMD_STOP: begin
               sda_en_q = 1'b1;
               if (p == PH_FIRST) sda_q = 1'b0;
               else if (p == PH_SECOND) scl_q = 1'b1;
               else begin
                  sda_q = 1'b1;
                  last  = 1'b1;
               end
            end
            CMD_WRITE: begin
               if (p < PH_WR_BITS_END) begin
                  // each data bit: set sda, raise scl, drop scl
                  case (p % 3)
                     0: begin
                        sda_en_q  = 1'b1;
                        sda_q     = shift_reg[7];
                        shift_reg = {shift_reg[6:0], 1'b0};
                     end
                     1: scl_q = 1'b1;
                     default: scl_q = 1'b0;
                  endcase
               end else if (p == PH_WR_BITS_END) begin
                  sda_en_q = 1'b1;
                  sda_q    = 1'b1;
               end else if (p == PH_WR_SCL_HIGH) scl_q = 1'b1;
               else begin
                  sda_en_q = 1'b0;
                  nack_q   = sda_in;
                  last     = 1'b1;
               end
            end
            default: begin
               if (p == PH_FIRST) scl_q = 1'b0;
               else if (p == PH_SECOND) sda_q = 1'b1;
               else if (p == PH_THIRD) sda_en_q = 1'b0;
               else if (p < PH_RD_BITS_END) begin
                  case (p % 3)
                     0: scl_q = 1'b1;
                     1: shift_reg = {shift_reg[6:0], sda_in};
                     default: scl_q = 1'b0;
                  endcase
               end else if (p == PH_RD_BITS_END) sda_en_q = 1'b1;
               else if (p == PH_RD_ACK_LVL) sda_q = !ack_sel;
               else if (p == PH_RD_SCL_HIGH) scl_q = 1'b1;
               else begin
                  scl_q     = 1'b0;
                  rd_byte_q = shift_reg;
                  last      = 1'b1;
               end
            end
         endcase
         if (last) begin
            r.done_res = 1'b1;
            cmd_busy   = 1'b0;
            bus_phase  = PH_FIRST;
         end else begin
            bus_phase = bus_phase + 5'd1;
         end
      end
      r.scl       = scl_q;
      r.sda_out   = sda_q;
      r.sda_drive = sda_en_q;
      r.read_data = rd_byte_q;
      r.nack      = nack_q;
      // lines after the write acknowledge settle only for the next item
      if (r.done_res && bus_cmd == CMD_WRITE) begin
         sda_en_q = 1'b1;
         scl_q    = 1'b0;
      end
      return r;
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         bus_phase = PH_FIRST;
         bus_cmd   = CMD_START;
         shift_reg = 8'h00;
         ack_sel   = 1'b0;
         cmd_busy  = 1'b0;
         scl_q     = 1'b1;
         sda_q     = 1'b1;
         sda_en_q  = 1'b1;
         nack_q    = 1'b0;
         rd_byte_q = 8'h00;
         expected_lines.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_lines.size() == 0) begin
               $display("%0t: response item with none expected, expected none, actual %0h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_lines.pop_front();
               got  = rsp_type'(rsp_tdata[13:0]);
               compare_field("scl", want.scl, got.scl);
               compare_field("sda_out", want.sda_out, got.sda_out);
               compare_field("sda_drive", want.sda_drive, got.sda_drive);
               compare_field("busy_res", want.busy_res, got.busy_res);
               compare_field("done_res", want.done_res, got.done_res);
               compare_field("read_data", want.read_data, got.read_data);
               compare_field("nack", want.nack, got.nack);
               compare_field("padding", 0, rsp_tdata[15:14]);
            end
         end
         if (req_tvalid && req_tready)
            expected_lines.push_back(advance_bus_phase(req_tuser, req_tdata[7:0],
                                                       req_tdata[8], req_tdata[9]));
      end
      outstanding = expected_lines.size();
   end

endmodule

>>> tb/i2c_bit_level_master_tb.sv
// Testbench top for the I2C bit-level master: clock, reset, command stimulus and verdict.
// Depends on i2cbm_pkg, i2c_bit_level_master and i2cbm_line_checker.
module i2c_bit_level_master_tb;
   import i2cbm_pkg::*;

   localparam logic [1:0] SDA_LOW    = 2'd0;
   localparam logic [1:0] SDA_HIGH   = 2'd1;
   localparam logic [1:0] SDA_RANDOM = 2'd2;
   localparam int ITEM_TARGET = 1400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = FUNC_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    mismatches;
   int                    outstanding;
   int                    items_sent = 0;
   bit                    calm = 1'b0;

   i2c_bit_level_master dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   i2cbm_line_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int bus_phases(input logic [2:0] func);
      case (func)
         FUNC_START: return 2;
         FUNC_STOP:  return 3;
         FUNC_WRITE: return 27;
         FUNC_READ:  return 31;
         default:    return 1;
      endcase
   endfunction

   task automatic send_item(input logic [2:0] func, input logic [7:0] wr, input logic ack,
                            input logic sda);
      int gap;
      gap = calm ? 0 : $urandom_range(15);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= REQ_DATA_W'({sda, ack, wr});
      do @(posedge clock); while (!req_tready);
      items_sent++;
      // alternate stretches with and without idle cycles on both sides
      if (items_sent % 200 == 0) calm = !calm;
   endtask

   function automatic logic pick_sda(input logic [1:0] mode);
      if (mode == SDA_RANDOM) return 1'($urandom_range(1));
      return mode == SDA_HIGH;
   endfunction

   // one command and the ticks that carry it to its end; busy ticks may hold stray commands
   task automatic run_command(input logic [2:0] func, input logic [7:0] wr, input logic ack,
                              input logic [1:0] sda_mode, input bit noisy);
      int         n;
      logic [2:0] filler;
      n = bus_phases(func);
      send_item(func, wr, ack, pick_sda(sda_mode));
      for (int i = 1; i < n; i++) begin
         filler = noisy && $urandom_range(2) == 0 ? 3'($urandom_range(7)) : FUNC_TICK;
         send_item(filler, 8'($urandom), 1'($urandom_range(1)), pick_sda(sda_mode));
      end
   endtask

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(15);
         repeat (stall) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      bit         paused;
      logic [2:0] func;
      int         stall;
      paused = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_command(FUNC_TICK, 8'h00, 1'b0, SDA_LOW, 1'b0);
      run_command(FUNC_START, 8'hFF, 1'b1, SDA_HIGH, 1'b0);
      run_command(FUNC_WRITE, 8'h00, 1'b0, SDA_LOW, 1'b0);
      run_command(FUNC_WRITE, 8'hFF, 1'b1, SDA_HIGH, 1'b0);
      run_command(FUNC_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 1'b1);
      run_command(FUNC_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
      run_command(FUNC_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0);
      run_command(FUNC_READ, 8'h5A, 1'b1, SDA_RANDOM, 1'b1);
      run_command(FUNC_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
      // unused func codes act as plain ticks
      for (int k = 1; k <= 3; k++)
         run_command(3'(FUNC_READ + k), 8'hFF, 1'b1, SDA_RANDOM, 1'b0);
      run_command(FUNC_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
      run_command(FUNC_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);

      while (items_sent < ITEM_TARGET) begin
         if (!paused && items_sent >= ITEM_TARGET / 2) begin
            paused = 1'b1;
            // drop valid so the last item is not offered again while draining
            req_tvalid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         if ($urandom_range(9) == 0) begin
            stall = $urandom_range(3);
            func  = (stall == 0) ? FUNC_TICK : 3'(FUNC_READ + stall);
            run_command(func, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 1'b0);
         end else begin
            func = 3'(FUNC_START + $urandom_range(3));
            run_command(func, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM,
                        $urandom_range(3) == 0);
         end
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> i2c_bit_level_master.f
src/i2cbm_pkg.sv
src/i2cbm_phase.sv
src/i2c_bit_level_master.sv
tb/i2cbm_line_checker.sv
tb/i2c_bit_level_master_tb.sv
